FILE: rtl/core/ytb_pkg.sv
package ytb_pkg;

  localparam int FW_W     = 13;
  localparam int FH_W     = 13;
  localparam int RS_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;
  localparam int COL_W    = 14;
  localparam int PROD_W   = 31;
  localparam int SUM_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd2;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [RS_W-1:0] ROW_STRIDE_RST   = 15'd1280;
  localparam logic [RS_W-1:0] STRIDE_LIMIT     = 15'd16384;

  localparam logic [1:0] LANE_Y0 = 2'd0;
  localparam logic [1:0] LANE_U  = 2'd1;
  localparam logic [1:0] LANE_Y1 = 2'd2;
  localparam logic [1:0] LANE_V  = 2'd3;

  localparam logic signed [22:0] COEF_Y  = 23'sd1220542;
  localparam logic signed [22:0] COEF_UB = 23'sd2116026;
  localparam logic signed [22:0] COEF_UG = -23'sd409993;
  localparam logic signed [22:0] COEF_VG = -23'sd852492;
  localparam logic signed [22:0] COEF_VR = 23'sd1673527;
  localparam int FRAC_BITS = 20;
  localparam logic signed [SUM_W-1:0] HALF_LSB = 32'sd524288;
  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [8:0] CHROMA_OFFSET = 9'd128;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hff;

  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] u;
    logic [7:0] v;
    logic       eor;
    logic       eof;
  } ytb_yuv_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] y0p;
    logic signed [PROD_W-1:0] y1p;
    logic signed [PROD_W-1:0] bu;
    logic signed [PROD_W-1:0] gu;
    logic signed [PROD_W-1:0] gv;
    logic signed [PROD_W-1:0] rv;
    logic                     eor;
    logic                     eof;
  } ytb_prod_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       eor;
    logic       eof;
  } ytb_pix_t;

  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] s);
    logic [7:0] q;
    if (s[SUM_W-1]) begin
      q = 8'd0;
    end else if (|s[SUM_W-2:FRAC_BITS+8]) begin
      q = 8'hff;
    end else begin
      q = s[FRAC_BITS+7:FRAC_BITS];
    end
    return q;
  endfunction

endpackage

FILE: rtl/core/ytb_unpack.sv
module ytb_unpack #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_source_byte,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ytb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ytb_pkg::CFG_DAT_W-1:0]     cfg_data,
  output logic                              s1_valid,
  input  logic                              s1_ready,
  output ytb_pkg::ytb_yuv_t                 s1_data
);

  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [13:0] WMAX = 14'(MAX_WIDTH & ~1);
  localparam logic [13:0] HMAX = 14'(MAX_HEIGHT);

  logic [ytb_pkg::FW_W-1:0]  frame_width_r;
  logic [ytb_pkg::FH_W-1:0]  frame_height_r;
  logic [ytb_pkg::RS_W-1:0]  row_stride_r;
  logic [ytb_pkg::COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [7:0]                y0_r, y0_nxt;
  logic [7:0]                u_r, u_nxt;
  logic [7:0]                y1_r, y1_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  ytb_pkg::ytb_yuv_t         s1_r;

  logic [13:0]               w_eff;
  logic [13:0]               h_eff;
  logic [ytb_pkg::RS_W-1:0]  w2;
  logic [ytb_pkg::RS_W-1:0]  stride;
  logic [ytb_pkg::RS_W-1:0]  col_inc;
  logic [13:0]               row_ext;
  logic                      active;
  logic                      fire;
  logic                      load;
  logic                      eor;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid_r || s1_ready;
  assign fire      = in_valid && in_ready;
  assign s1_valid  = s1_valid_r;
  assign s1_data   = s1_r;

  always_comb begin
    w_eff = {1'b0, frame_width_r[ytb_pkg::FW_W-1:1], 1'b0};
    if (w_eff < 14'd2) begin
      w_eff = 14'd2;
    end
    if (w_eff > WMAX) begin
      w_eff = WMAX;
    end
    h_eff = {1'b0, frame_height_r};
    if (h_eff < 14'd1) begin
      h_eff = 14'd1;
    end
    if (h_eff > HMAX) begin
      h_eff = HMAX;
    end
    w2 = {w_eff, 1'b0};
    stride = row_stride_r;
    if (stride < w2) begin
      stride = w2;
    end
    if (stride > ytb_pkg::STRIDE_LIMIT) begin
      stride = ytb_pkg::STRIDE_LIMIT;
    end
  end

  always_comb begin
    col_inc = {1'b0, col_r} + 15'd1;
    row_ext = 14'(row_r);
    active  = {1'b0, col_r} < w2;
    eor     = ({1'b0, col_r} == w2 - 15'd1);
    load    = fire && active && (col_r[1:0] == ytb_pkg::LANE_V);

    y0_nxt = y0_r;
    u_nxt  = u_r;
    y1_nxt = y1_r;
    if (fire && active) begin
      case (col_r[1:0])
        ytb_pkg::LANE_Y0: y0_nxt = in_source_byte;
        ytb_pkg::LANE_U:  u_nxt  = in_source_byte;
        ytb_pkg::LANE_Y1: y1_nxt = in_source_byte;
        default:          y0_nxt = y0_r;
      endcase
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (fire) begin
      if (col_inc >= stride) begin
        col_nxt = '0;
        if (row_ext + 14'd1 >= h_eff) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_inc[ytb_pkg::COL_W-1:0];
      end
    end

    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ytb_pkg::FRAME_WIDTH_RST;
      frame_height_r <= ytb_pkg::FRAME_HEIGHT_RST;
      row_stride_r   <= ytb_pkg::ROW_STRIDE_RST;
      col_r          <= '0;
      row_r          <= '0;
      y0_r           <= '0;
      u_r            <= '0;
      y1_r           <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ytb_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[ytb_pkg::FW_W-1:0];
          ytb_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[ytb_pkg::FH_W-1:0];
          ytb_pkg::REG_ROW_STRIDE:   row_stride_r   <= cfg_data[ytb_pkg::RS_W-1:0];
          default:                   row_stride_r   <= row_stride_r;
        endcase
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      y0_r       <= y0_nxt;
      u_r        <= u_nxt;
      y1_r       <= y1_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r.y0  <= y0_r;
      s1_r.y1  <= y1_r;
      s1_r.u   <= u_r;
      s1_r.v   <= in_source_byte;
      s1_r.eor <= eor;
      s1_r.eof <= eor && (row_ext >= h_eff - 14'd1);
    end
  end

endmodule

FILE: rtl/core/ytb_mult.sv
module ytb_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  ytb_pkg::ytb_yuv_t  s1_data,
  output logic               s2_valid,
  input  logic               s2_ready,
  output ytb_pkg::ytb_prod_t s2_data
);

  localparam int PW = ytb_pkg::PROD_W;

  logic               s2_valid_r, s2_valid_nxt;
  ytb_pkg::ytb_prod_t s2_r, s2_nxt;
  logic               load;
  logic [7:0]         yl0, yl1;
  logic signed [8:0]  u, v;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;
  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

  always_comb begin
    yl0 = (s1_data.y0 >= ytb_pkg::LUMA_OFFSET) ? s1_data.y0 - ytb_pkg::LUMA_OFFSET : 8'd0;
    yl1 = (s1_data.y1 >= ytb_pkg::LUMA_OFFSET) ? s1_data.y1 - ytb_pkg::LUMA_OFFSET : 8'd0;
    u   = signed'({1'b0, s1_data.u} - ytb_pkg::CHROMA_OFFSET);
    v   = signed'({1'b0, s1_data.v} - ytb_pkg::CHROMA_OFFSET);
    s2_nxt.y0p = PW'(signed'({1'b0, yl0})) * PW'(ytb_pkg::COEF_Y);
    s2_nxt.y1p = PW'(signed'({1'b0, yl1})) * PW'(ytb_pkg::COEF_Y);
    s2_nxt.bu  = PW'(u) * PW'(ytb_pkg::COEF_UB);
    s2_nxt.gu  = PW'(u) * PW'(ytb_pkg::COEF_UG);
    s2_nxt.gv  = PW'(v) * PW'(ytb_pkg::COEF_VG);
    s2_nxt.rv  = PW'(v) * PW'(ytb_pkg::COEF_VR);
    s2_nxt.eor = s1_data.eor;
    s2_nxt.eof = s1_data.eof;

    if (load) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

FILE: rtl/core/ytb_pixout.sv
module ytb_pixout (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s2_valid,
  output logic               s2_ready,
  input  ytb_pkg::ytb_prod_t s2_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ytb_pkg::ytb_pix_t  out_pix
);

  localparam int SW = ytb_pkg::SUM_W;

  logic              pv_r, pv_nxt;
  logic              sel_r, sel_nxt;
  ytb_pkg::ytb_pix_t pix0_r, pix1_r;
  ytb_pkg::ytb_pix_t pix0_nxt, pix1_nxt;
  logic              load;
  logic              out_fire;
  logic signed [SW-1:0] b_uv, g_uv, r_uv, y0, y1;

  assign out_fire  = pv_r && out_ready;
  assign s2_ready  = !pv_r || (sel_r && out_ready);
  assign load      = s2_valid && s2_ready;
  assign out_valid = pv_r;
  assign out_pix   = sel_r ? pix1_r : pix0_r;

  always_comb begin
    b_uv = ytb_pkg::HALF_LSB + SW'(s2_data.bu);
    g_uv = ytb_pkg::HALF_LSB + SW'(s2_data.gv) + SW'(s2_data.gu);
    r_uv = ytb_pkg::HALF_LSB + SW'(s2_data.rv);
    y0   = SW'(s2_data.y0p);
    y1   = SW'(s2_data.y1p);

    pix0_nxt.blue  = ytb_pkg::clamp_channel(y0 + b_uv);
    pix0_nxt.green = ytb_pkg::clamp_channel(y0 + g_uv);
    pix0_nxt.red   = ytb_pkg::clamp_channel(y0 + r_uv);
    pix0_nxt.eor   = 1'b0;
    pix0_nxt.eof   = 1'b0;
    pix1_nxt.blue  = ytb_pkg::clamp_channel(y1 + b_uv);
    pix1_nxt.green = ytb_pkg::clamp_channel(y1 + g_uv);
    pix1_nxt.red   = ytb_pkg::clamp_channel(y1 + r_uv);
    pix1_nxt.eor   = s2_data.eor;
    pix1_nxt.eof   = s2_data.eof;

    pv_nxt  = pv_r;
    sel_nxt = sel_r;
    if (load) begin
      pv_nxt  = 1'b1;
      sel_nxt = 1'b0;
    end else if (out_fire) begin
      if (sel_r) begin
        pv_nxt  = 1'b0;
        sel_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      pv_r  <= pv_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix0_r <= pix0_nxt;
      pix1_r <= pix1_nxt;
    end
  end

endmodule

FILE: rtl/core/yuyv_to_bgra_converter_unit.sv
// Path: a pixel pair enters the unpack register with its V byte, then the product register
// and the pixel buffer; the second pixel follows the first on the next output beat.
// Throughput: one source byte per cycle with out_ready high and one pixel per output beat
// (two pixels per four bytes), set by the unpack stage, the product stage and the two-entry
// pixel buffer. Reset (rst_n low at a clock edge): counters, held bytes and pipeline valids
// clear and the registers return to width 640, height 480, stride 1280.
module yuyv_to_bgra_converter_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_source_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_alpha,
  output logic                          out_end_of_row,
  output logic                          out_end_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ytb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ytb_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic               s1_valid, s1_ready;
  ytb_pkg::ytb_yuv_t  s1_data;
  logic               s2_valid, s2_ready;
  ytb_pkg::ytb_prod_t s2_data;
  ytb_pkg::ytb_pix_t  pix;

  ytb_unpack #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_unpack (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_byte (in_source_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1_data        (s1_data)
  );

  ytb_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  ytb_pixout u_pixout (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (pix)
  );

  assign out_blue         = pix.blue;
  assign out_green        = pix.green;
  assign out_red          = pix.red;
  assign out_alpha        = ytb_pkg::ALPHA_OPAQUE;
  assign out_end_of_row   = pix.eor;
  assign out_end_of_frame = pix.eof;

endmodule

FILE: sim/yuyv_to_bgra_converter_unit_tb.sv
module yuyv_to_bgra_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       eor;
    logic       eof;
  } pixel_t;

  typedef struct {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    bit         typed;
    logic [7:0] gray0;
    logic [7:0] gray1;
  } group_row_t;

  localparam longint K_Y  = 1220542;
  localparam longint K_UB = 2116026;
  localparam longint K_UG = -409993;
  localparam longint K_VG = -852492;
  localparam longint K_VR = 1673527;
  localparam longint HALF_STEP = 524288;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_source_byte = 8'd0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    out_blue;
  logic [7:0]                    out_green;
  logic [7:0]                    out_red;
  logic [7:0]                    out_alpha;
  logic                          out_end_of_row;
  logic                          out_end_of_frame;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ytb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ytb_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  logic [12:0] reg_width = 13'd640;
  logic [12:0] reg_height = 13'd480;
  logic [14:0] reg_stride = 15'd1280;
  logic [13:0] col_pos = '0;
  logic [11:0] row_pos = '0;
  logic [7:0]  hold_y0 = '0;
  logic [7:0]  hold_u = '0;
  logic [7:0]  hold_y1 = '0;
  pixel_t      pair_px [2];
  pixel_t      pixels_due [$];

  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int pixels_checked = 0;
  int rows_seen = 0;
  int frames_seen = 0;
  int geometries = 0;

  group_row_t dir_groups [6] = '{
    '{8'd16,  8'd128, 8'd16,  8'd128, 1'b1, 8'd0,   8'd0},
    '{8'd255, 8'd128, 8'd0,   8'd128, 1'b1, 8'd255, 8'd0},
    '{8'd235, 8'd128, 8'd235, 8'd128, 1'b1, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0},
    '{8'd128, 8'd0,   8'd127, 8'd255, 1'b0, 8'd0,   8'd0}
  };

  yuyv_to_bgra_converter_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_byte   (in_source_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_alpha        (out_alpha),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] sat_channel(input longint acc);
    if (acc < 0) begin
      return 8'd0;
    end
    if ((acc >>> 20) > 255) begin
      return 8'hff;
    end
    return acc[27:20];
  endfunction

  function automatic pixel_t shade_pixel(input logic [7:0] luma, input longint r_uv,
                                         input longint g_uv, input longint b_uv,
                                         input logic eor, input logic eof);
    longint yl;
    pixel_t p;
    yl = (luma > 8'd16) ? (longint'(luma) - 16) * K_Y : 0;
    p.blue  = sat_channel(yl + b_uv);
    p.green = sat_channel(yl + g_uv);
    p.red   = sat_channel(yl + r_uv);
    p.alpha = 8'hff;
    p.eor   = eor;
    p.eof   = eof;
    return p;
  endfunction

  function automatic int predict_byte(input logic [7:0] b);
    int unsigned wid;
    int unsigned w2;
    int unsigned hgt;
    int unsigned strd;
    longint du;
    longint dv;
    longint r_uv;
    longint g_uv;
    longint b_uv;
    logic eor;
    int n;
    wid = {reg_width[12:1], 1'b0};
    if (wid < 2) wid = 2;
    if (wid > 4096) wid = 4096;
    w2 = 2 * wid;
    hgt = reg_height;
    if (hgt == 0) hgt = 1;
    if (hgt > 4096) hgt = 4096;
    strd = reg_stride;
    if (strd < w2) strd = w2;
    if (strd > 16384) strd = 16384;
    n = 0;
    if (col_pos < w2) begin
      case (col_pos[1:0])
        ytb_pkg::LANE_Y0: hold_y0 = b;
        ytb_pkg::LANE_U:  hold_u = b;
        ytb_pkg::LANE_Y1: hold_y1 = b;
        default: begin
          du = longint'(hold_u) - 128;
          dv = longint'(b) - 128;
          r_uv = HALF_STEP + K_VR * dv;
          g_uv = HALF_STEP + K_VG * dv + K_UG * du;
          b_uv = HALF_STEP + K_UB * du;
          eor = (col_pos == w2 - 1);
          pair_px[0] = shade_pixel(hold_y0, r_uv, g_uv, b_uv, 1'b0, 1'b0);
          pair_px[1] = shade_pixel(hold_y1, r_uv, g_uv, b_uv, eor,
                                   eor && (row_pos >= hgt - 1));
          n = 2;
        end
      endcase
    end
    if (col_pos + 1 >= strd) begin
      col_pos = '0;
      row_pos = (row_pos + 1 >= hgt) ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 14'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'd16;
      3: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [7:0] gray0 = 8'd0, input logic [7:0] gray1 = 8'd0);
    int n;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_source_byte = b;
    do @(posedge clk); while (!in_ready);
    n = predict_byte(b);
    bytes_sent++;
    if (n == 2) begin
      if (typed) begin
        pixels_due.push_back(pixel_t'{gray0, gray0, gray0, 8'hff, 1'b0, 1'b0});
        pixels_due.push_back(pixel_t'{gray1, gray1, gray1, 8'hff, 1'b0, 1'b0});
      end else begin
        pixels_due.push_back(pair_px[0]);
        pixels_due.push_back(pair_px[1]);
      end
    end
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ytb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ytb_pkg::CFG_DAT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ytb_pkg::REG_FRAME_WIDTH:  reg_width = data[12:0];
      ytb_pkg::REG_FRAME_HEIGHT: reg_height = data[12:0];
      ytb_pkg::REG_ROW_STRIDE:   reg_stride = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_geometry(input int w, input int h, input int s);
    settle();
    write_reg(ytb_pkg::REG_FRAME_WIDTH, 15'(w));
    write_reg(ytb_pkg::REG_FRAME_HEIGHT, 15'(h));
    write_reg(ytb_pkg::REG_ROW_STRIDE, 15'(s));
    cfg_valid = 1'b0;
    geometries++;
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch("pixel with none pending, blue", out_blue, 0);
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_alpha !== want.alpha) report_mismatch("alpha", out_alpha, want.alpha);
        if (out_end_of_row !== want.eor) begin
          report_mismatch("end_of_row", out_end_of_row, want.eor);
        end
        if (out_end_of_frame !== want.eof) begin
          report_mismatch("end_of_frame", out_end_of_frame, want.eof);
        end
        if (want.eor) rows_seen++;
        if (want.eof) frames_seen++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_groups[i]) begin
      send_byte(dir_groups[i].y0);
      send_byte(dir_groups[i].u);
      send_byte(dir_groups[i].y1);
      send_byte(dir_groups[i].v, dir_groups[i].typed, dir_groups[i].gray0,
                dir_groups[i].gray1);
    end

    // widest row, single-row frame, stride taken from width
    set_geometry(8191, 0, 0);
    repeat (16) send_byte(pick_byte());
    // narrowest row with long padding, then cut the stride mid-row
    set_geometry(1, 8191, 32767);
    repeat (10) send_byte(pick_byte());
    set_geometry(1, 8191, 4);
    repeat (6) send_byte(pick_byte());
    set_geometry(5, 2, 3);
    repeat (40) send_byte(pick_byte());
    set_geometry(4096, 4096, 16384);
    repeat (12) send_byte(pick_byte());

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 82; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 82; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      repeat (2) begin
        set_geometry($urandom_range(0, 12), $urandom_range(0, 4), $urandom_range(0, 36));
        for (int k = 0; k < 40; k++) begin
          if (k == 20) settle();
          send_byte(pick_byte());
        end
      end
    end
    settle();

    $display("Covered %0d source bytes and %0d pixels (%0d row ends, %0d frame ends)",
             bytes_sent, pixels_checked, rows_seen, frames_seen);
    $display("across %0d geometry settings and four pacing mixes on both channels.",
             geometries);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ytb_pkg.sv
rtl/core/ytb_unpack.sv
rtl/core/ytb_mult.sv
rtl/core/ytb_pixout.sv
rtl/core/yuyv_to_bgra_converter_unit.sv
sim/yuyv_to_bgra_converter_unit_tb.sv
